// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int R_W        = DATA_WIDTH + 3;
  localparam int NUM_W      = DATA_WIDTH + 1;
  localparam int V_W        = 2 * DATA_WIDTH;
  localparam int SQ_W       = DATA_WIDTH;
  localparam int REM_W      = SQ_W + 2;
  localparam int Q_W        = DATA_WIDTH + FRAC_BITS / 2 + 2;
  localparam int DVD_W      = NUM_W + FRAC_BITS + 1;
  localparam int LANES      = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  localparam elem_t MAX_Q = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam elem_t MIN_Q = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [R_W-1:0] ONE_Q = R_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'((1 << (DATA_WIDTH-1)) - 1);
  localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(1) << (DATA_WIDTH-1);

  typedef struct packed {
    elem_t m00; elem_t m01; elem_t m02;
    elem_t m10; elem_t m11; elem_t m12;
    elem_t m20; elem_t m21; elem_t m22;
  } item_t;

  typedef struct packed {
    elem_t qx; elem_t qy; elem_t qz; elem_t qw;
    logic  bad_input;
  } result_t;

  // which component is the large one
  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z, SEL_W} sel_t;

  // classified work handed from front to back
  typedef struct packed {
    sel_t                         sel;
    logic                         r_bad;
    logic [V_W-1:0]               v;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][NUM_W-1:0]  mag;
  } job_t;

endpackage

// ===== sv/rmq_front.sv =====
// Front end: branch choice, radicand and off-diagonal numerators.
module rmq_front (
  input  rmq_pkg::item_t item,
  output rmq_pkg::job_t  job
);
  import rmq_pkg::*;

  logic signed [R_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [R_W-1:0] tr, rad;
  logic signed [R_W-1:0] d12, d20, d01, s10, s20, s21;
  logic signed [R_W-1:0] n [LANES];
  logic signed [R_W-1:0] a [LANES];
  sel_t                  sel;

  always_comb begin
    e00 = R_W'(item.m00); e01 = R_W'(item.m01); e02 = R_W'(item.m02);
    e10 = R_W'(item.m10); e11 = R_W'(item.m11); e12 = R_W'(item.m12);
    e20 = R_W'(item.m20); e21 = R_W'(item.m21); e22 = R_W'(item.m22);
    tr  = e00 + e11 + e22;
    d12 = e12 - e21;
    d20 = e20 - e02;
    d01 = e01 - e10;
    s10 = e10 + e01;
    s20 = e20 + e02;
    s21 = e21 + e12;

    priority if (tr > 0) begin
      sel = SEL_W;
      rad = ONE_Q + tr;
    end else if (e00 > e11 && e00 > e22) begin
      sel = SEL_X;
      rad = ONE_Q + e00 - e11 - e22;
    end else if (e11 > e22) begin
      sel = SEL_Y;
      rad = ONE_Q + e11 - e00 - e22;
    end else begin
      sel = SEL_Z;
      rad = ONE_Q + e22 - e00 - e11;
    end

    // lanes hold the three small components in x, y, z, w order
    unique case (sel)
      SEL_W: begin n[0] = d12; n[1] = d20; n[2] = d01; end
      SEL_X: begin n[0] = s10; n[1] = s20; n[2] = d12; end
      SEL_Y: begin n[0] = s10; n[1] = s21; n[2] = d20; end
      SEL_Z: begin n[0] = s20; n[1] = s21; n[2] = d01; end
      default: begin n[0] = d12; n[1] = d20; n[2] = d01; end
    endcase

    job.sel   = sel;
    job.r_bad = (rad <= 0);
    job.v     = V_W'(rad[R_W-2:0]) << FRAC_BITS;
    for (int i = 0; i < LANES; i++) begin
      job.neg[i] = n[i][R_W-1];
      a[i]       = n[i][R_W-1] ? -n[i] : n[i];
      job.mag[i] = a[i][NUM_W-1:0];
    end
  end

endmodule

// ===== sv/rmq_queue.sv =====
// Short queue of classified jobs between front and back.
module rmq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rmq_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output rmq_pkg::job_t dout,
  output logic          empty
);
  import rmq_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   cnt;
  logic              do_push, do_pop;

  assign full    = (cnt == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

endmodule

// ===== sv/rmq_back.sv =====
// Back end: pipelined square root, three pipelined dividers, saturation, result buffer.
module rmq_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  rmq_pkg::job_t    job,
  output logic             job_pop,
  output rmq_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import rmq_pkg::*;

  typedef struct packed {
    sel_t                         sel;
    logic                         r_bad;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][NUM_W-1:0]  mag;
    logic [V_W-1:0]               v;
    logic [REM_W-1:0]             rem;
    logic [SQ_W-1:0]              root;
  } sq_t;

  typedef struct packed {
    sel_t                         sel;
    logic                         r_bad;
    logic [SQ_W-1:0]              h;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][REM_W-1:0]  rem;
    logic [LANES-1:0][Q_W-1:0]    dvdl;
    logic [LANES-1:0][Q_W-1:0]    quo;
  } dv_t;

  sq_t     sq     [SQ_W+1];
  logic    sq_vld [SQ_W+1];
  dv_t     dv     [Q_W+1];
  logic    dv_vld [Q_W+1];
  result_t ob     [2];
  logic    ob_wr, ob_rd;
  logic [1:0] ob_cnt;
  logic    en, ob_push, ob_pop;
  result_t fin;

  // whole pipe advances while the result buffer has room
  assign en      = (ob_cnt != 2'd2);
  assign job_pop = en && job_valid;
  assign ob_push = en && dv_vld[Q_W];
  assign ob_pop  = pop && !empty;
  assign empty   = (ob_cnt == 2'd0);
  assign result  = ob[ob_rd];

  // load square root stage
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].sel   <= job.sel;
      sq[0].r_bad <= job.r_bad;
      sq[0].neg   <= job.neg;
      sq[0].mag   <= job.mag;
      sq[0].v     <= job.v;
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= job_valid;
  end

  // one root bit per stage
  for (genvar k = 0; k < SQ_W; k++) begin : g_sq
    logic [REM_W-1:0] rem2, trial;
    assign rem2  = {sq[k].rem[REM_W-3:0], sq[k].v[V_W-1 -: 2]};
    assign trial = {sq[k].root, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1].sel   <= sq[k].sel;
        sq[k+1].r_bad <= sq[k].r_bad;
        sq[k+1].neg   <= sq[k].neg;
        sq[k+1].mag   <= sq[k].mag;
        sq[k+1].v     <= sq[k].v << 2;
        if (rem2 >= trial) begin
          sq[k+1].rem  <= rem2 - trial;
          sq[k+1].root <= {sq[k].root[SQ_W-2:0], 1'b1};
        end else begin
          sq[k+1].rem  <= rem2;
          sq[k+1].root <= {sq[k].root[SQ_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (en) sq_vld[k+1] <= sq_vld[k];
    end
  end

  // divider setup: dividend = mag * 2^F + h, divisor = 2h
  logic [DVD_W-1:0] dvd [LANES];
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dvd[i] = (DVD_W'(sq[SQ_W].mag[i]) << FRAC_BITS) + DVD_W'(sq[SQ_W].root);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].sel   <= sq[SQ_W].sel;
      dv[0].r_bad <= sq[SQ_W].r_bad;
      dv[0].h     <= sq[SQ_W].root;
      dv[0].neg   <= sq[SQ_W].neg;
      for (int i = 0; i < LANES; i++) begin
        dv[0].rem[i]  <= REM_W'(dvd[i] >> Q_W);
        dv[0].dvdl[i] <= dvd[i][Q_W-1:0];
        dv[0].quo[i]  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= sq_vld[SQ_W];
  end

  // one quotient bit per stage in each lane
  for (genvar k = 0; k < Q_W; k++) begin : g_dv
    logic [REM_W-1:0] rem2 [LANES];
    logic [REM_W-1:0] dvs;
    assign dvs = REM_W'({dv[k].h, 1'b0});

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        rem2[i] = {dv[k].rem[i][REM_W-2:0], dv[k].dvdl[i][Q_W-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1].sel   <= dv[k].sel;
        dv[k+1].r_bad <= dv[k].r_bad;
        dv[k+1].h     <= dv[k].h;
        dv[k+1].neg   <= dv[k].neg;
        for (int i = 0; i < LANES; i++) begin
          dv[k+1].dvdl[i] <= dv[k].dvdl[i] << 1;
          if (rem2[i] >= dvs) begin
            dv[k+1].rem[i] <= rem2[i] - dvs;
            dv[k+1].quo[i] <= {dv[k].quo[i][Q_W-2:0], 1'b1};
          end else begin
            dv[k+1].rem[i] <= rem2[i];
            dv[k+1].quo[i] <= {dv[k].quo[i][Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (en) dv_vld[k+1] <= dv_vld[k];
    end
  end

  // saturate a signed magnitude; returns {overflow, value}
  function automatic logic [DATA_WIDTH:0] sat_lane(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W-1:0] nq;
    nq = Q_W'(0) - q;
    if (!neg) begin
      if (q > Q_POS_LIM) sat_lane = {1'b1, MAX_Q};
      else               sat_lane = {1'b0, q[DATA_WIDTH-1:0]};
    end else begin
      if (q > Q_NEG_LIM) sat_lane = {1'b1, MIN_Q};
      else               sat_lane = {1'b0, nq[DATA_WIDTH-1:0]};
    end
  endfunction

  logic [DATA_WIDTH:0] ls [LANES];
  logic [DATA_WIDTH:0] bs;
  logic [SQ_W:0]       big;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ls[i] = sat_lane(dv[Q_W].neg[i], dv[Q_W].quo[i]);
    end
    big = ({1'b0, dv[Q_W].h} + 1'b1) >> 1;
    if (big > (SQ_W+1)'(Q_POS_LIM)) bs = {1'b1, MAX_Q};
    else                            bs = {1'b0, big[DATA_WIDTH-1:0]};

    unique case (dv[Q_W].sel)
      SEL_W: begin
        fin.qx = ls[0][DATA_WIDTH-1:0]; fin.qy = ls[1][DATA_WIDTH-1:0];
        fin.qz = ls[2][DATA_WIDTH-1:0]; fin.qw = bs[DATA_WIDTH-1:0];
      end
      SEL_X: begin
        fin.qx = bs[DATA_WIDTH-1:0];    fin.qy = ls[0][DATA_WIDTH-1:0];
        fin.qz = ls[1][DATA_WIDTH-1:0]; fin.qw = ls[2][DATA_WIDTH-1:0];
      end
      SEL_Y: begin
        fin.qx = ls[0][DATA_WIDTH-1:0]; fin.qy = bs[DATA_WIDTH-1:0];
        fin.qz = ls[1][DATA_WIDTH-1:0]; fin.qw = ls[2][DATA_WIDTH-1:0];
      end
      default: begin
        fin.qx = ls[0][DATA_WIDTH-1:0]; fin.qy = ls[1][DATA_WIDTH-1:0];
        fin.qz = bs[DATA_WIDTH-1:0];    fin.qw = ls[2][DATA_WIDTH-1:0];
      end
    endcase
    fin.bad_input = ls[0][DATA_WIDTH] | ls[1][DATA_WIDTH] | ls[2][DATA_WIDTH] |
                    bs[DATA_WIDTH];

    if (dv[Q_W].r_bad) begin
      fin = '0;
      fin.bad_input = 1'b1;
    end
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (ob_push) ob_wr <= ~ob_wr;
      if (ob_pop)  ob_rd <= ~ob_rd;
      unique case ({ob_push, ob_pop})
        2'b10:   ob_cnt <= ob_cnt + 2'd1;
        2'b01:   ob_cnt <= ob_cnt - 2'd1;
        default: ob_cnt <= ob_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob[ob_wr] <= fin;
  end

endmodule

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
// Top level of the rotation matrix to quaternion unit.
//
// Converts one 3x3 rotation matrix (nine signed Q1.14 elements) into a
// quaternion x, y, z, w in Q1.14 by Shepperd's method, plus a bad_input flag.
// Input side is a queue: drive item and push; a transaction completes on a
// clock edge with push high and full low. Result side is a queue too: result
// is valid while empty is low and a transaction completes on an edge with
// pop high and empty low.
// The front classifies the matrix (branch, radicand, off-diagonal terms) in
// the push cycle and writes it into a four-entry job queue. The back is one
// pipeline: DATA_WIDTH square root stages (one root bit each), a divider setup
// stage, Q_W divider stages (one quotient bit per stage in three parallel
// lanes) and a two-entry result buffer.
// Throughput: one matrix per cycle while the result buffer has room.
// When pop stays low the result buffer fills, the back pipeline holds, the
// job queue fills and full rises; nothing is dropped.
// Synchronous reset empties both queues and clears all pipeline valid bits.
module rotation_matrix_to_quaternion_unit (
  input  logic             clk,
  input  logic             rst,
  input  rmq_pkg::item_t   item,
  input  logic             push,
  output logic             full,
  output rmq_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import rmq_pkg::*;

  job_t front_job, queued_job;
  logic q_empty, q_pop;

  rmq_front u_front (
    .item (item),
    .job  (front_job)
  );

  rmq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_job),
    .full  (full),
    .pop   (q_pop),
    .dout  (queued_job),
    .empty (q_empty)
  );

  rmq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (queued_job),
    .job_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== sv/rmq_checker.sv =====
// Port-level checks for the rotation matrix to quaternion unit, with bind.
module rmq_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input rmq_pkg::result_t result
);
  import rmq_pkg::*;

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_ready_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("pending result changed or vanished without pop");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== sim/rotation_matrix_to_quaternion_unit_tb.sv =====
// Testbench for the rotation matrix to quaternion unit: directed and random matrices vs. a predictor.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_unit_tb;
  import rmq_pkg::*;

  // Fixed-point format of the block
  localparam int FB = DATA_WIDTH - 2;
  localparam longint ONE = longint'(1) << FB;
  localparam longint MAXV = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint MINV = -MAXV - 1;
  localparam int LATENCY = DATA_WIDTH + Q_W + 3;
  localparam longint CYCLE_LIMIT = 400000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  item_t   item = '0;
  logic    push = 1'b0;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop = 1'b0;

  result_t quat_expected[$];
  int      mismatches = 0;
  longint  cycles = 0;
  // receiver hold-off request, in cycles; served by the pop process
  int      pop_hold = 0;
  // when set, the pop process takes every result without gaps
  bit      pop_steady = 1'b0;

  rotation_matrix_to_quaternion_unit dut (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop)
  );

  always #5 clk = ~clk;

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // floor(sqrt(v)) by the digit-by-digit method
  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // num * 2^FB / (2h), nearest, ties away from zero
  function automatic longint scaled_div(longint num, longint h);
    longint a, q;
    a = (num < 0) ? -num : num;
    q = (a * ONE + h) / (2 * h);
    return (num < 0) ? -q : q;
  endfunction

  function automatic elem_t clamp(longint v, ref bit bad);
    if (v > MAXV) begin
      bad = 1'b1;
      return elem_t'(MAXV);
    end
    if (v < MINV) begin
      bad = 1'b1;
      return elem_t'(MINV);
    end
    return elem_t'(v);
  endfunction

  // Shepperd conversion at the block's precision
  function automatic result_t predict_quat(item_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, r, h, big;
    longint x, y, z, w;
    sel_t sel;
    bit bad;
    result_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    bad = 1'b0;
    q = '0;
    if (tr > 0) begin
      sel = SEL_W; r = ONE + tr;
    end else if (a00 > a11 && a00 > a22) begin
      sel = SEL_X; r = ONE + a00 - a11 - a22;
    end else if (a11 > a22) begin
      sel = SEL_Y; r = ONE + a11 - a00 - a22;
    end else begin
      sel = SEL_Z; r = ONE + a22 - a00 - a11;
    end
    if (r <= 0) begin
      q.bad_input = 1'b1;
      return q;
    end
    h = int_sqrt(r * ONE);
    big = (h + 1) >>> 1;
    case (sel)
      SEL_W: begin
        w = big; x = scaled_div(a12 - a21, h);
        y = scaled_div(a20 - a02, h); z = scaled_div(a01 - a10, h);
      end
      SEL_X: begin
        x = big; w = scaled_div(a12 - a21, h);
        y = scaled_div(a10 + a01, h); z = scaled_div(a20 + a02, h);
      end
      SEL_Y: begin
        y = big; w = scaled_div(a20 - a02, h);
        x = scaled_div(a10 + a01, h); z = scaled_div(a21 + a12, h);
      end
      default: begin
        z = big; w = scaled_div(a01 - a10, h);
        x = scaled_div(a20 + a02, h); y = scaled_div(a21 + a12, h);
      end
    endcase
    q.qx = clamp(x, bad);
    q.qy = clamp(y, bad);
    q.qz = clamp(z, bad);
    q.qw = clamp(w, bad);
    q.bad_input = bad;
    return q;
  endfunction

  // Mostly no gap, otherwise mostly short gaps and a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Send one matrix; returns once the transaction completes, push left high
  task automatic send_matrix(item_t m, bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item <= m;
    push <= 1'b1;
    quat_expected.push_back(predict_quat(m));
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Pop side: random idling, hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pop_hold > 0) begin
        pop <= 1'b0;
        repeat (pop_hold) @(posedge clk);
        pop_hold = 0;
      end
      g = pop_steady ? 0 : gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Checker: compare each completed result transaction to the oldest prediction
  always @(posedge clk) begin
    result_t exp_q;
    if (!rst && pop && !empty) begin
      if (quat_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        exp_q = quat_expected.pop_front();
        if (result.qx !== exp_q.qx || result.qy !== exp_q.qy ||
            result.qz !== exp_q.qz || result.qw !== exp_q.qw ||
            result.bad_input !== exp_q.bad_input) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp x=%0d y=%0d z=%0d w=%0d bad=%0b ",
                      "got x=%0d y=%0d z=%0d w=%0d bad=%0b"},
                     exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.bad_input,
                     result.qx, result.qy, result.qz, result.qw, result.bad_input);
        end
      end
    end
  end

  function automatic item_t mk(int a, int b, int c, int d, int e, int f, int g, int h,
                               int i);
    item_t m;
    m.m00 = elem_t'(a); m.m01 = elem_t'(b); m.m02 = elem_t'(c);
    m.m10 = elem_t'(d); m.m11 = elem_t'(e); m.m12 = elem_t'(f);
    m.m20 = elem_t'(g); m.m21 = elem_t'(h); m.m22 = elem_t'(i);
    return m;
  endfunction

  // Stop offering and wait until every expected result has come
  task automatic wait_drained();
    push <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
  endtask

  // Each branch, identity, diagonal ties, large off-diagonal terms, field extremes
  task automatic test_directed();
    int o;
    o = int'(ONE);
    send_matrix(mk(o, 0, 0, 0, o, 0, 0, 0, o));        // identity, trace branch
    send_matrix(mk(o, 0, 0, 0, -o, 0, 0, 0, -o));      // x branch
    send_matrix(mk(-o, 0, 0, 0, o, 0, 0, 0, -o));      // y branch
    send_matrix(mk(-o, 0, 0, 0, -o, 0, 0, 0, o));      // z branch
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));        // trace zero, tie to z branch
    send_matrix(mk(5, 0, 0, 0, 5, 0, 0, 0, 5));        // ties on the diagonal, trace positive
    send_matrix(mk(-5, 0, 0, 0, -5, 0, 0, 0, -5));     // negative equal diagonal
    send_matrix(mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767)); // large positive trace, trace branch
    send_matrix(mk(32767, 0, 0, 0, -32768, 0, 0, 0, 32767));
    send_matrix(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    send_matrix(mk(-o, 32767, -32768, 32767, -o, 32767, -32768, 32767, -o)); // large off-diagonal sums, z branch
    send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768));
    send_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_matrix(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));        // smallest positive trace
    send_matrix(mk(-o, 0, 0, 0, 0, 0, 0, 0, 0));       // z branch by tie
    send_matrix(mk(0, o, 0, -o, 0, 0, 0, 0, o));       // 90 deg about z
    send_matrix(mk(o, 0, 0, 0, 0, -o, 0, o, 0));       // 90 deg about x
    send_matrix(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // Random unit-scale matrices plus raw noise
  task automatic test_random(int n);
    item_t m;
    int k, o;
    o = int'(ONE);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 70) begin
        // signed unit-scale entries, each uniform in [-ONE, ONE]
        m = mk($urandom_range(2 * o) - o, $urandom_range(2 * o) - o,
               $urandom_range(2 * o) - o, $urandom_range(2 * o) - o,
               $urandom_range(2 * o) - o, $urandom_range(2 * o) - o,
               $urandom_range(2 * o) - o, $urandom_range(2 * o) - o,
               $urandom_range(2 * o) - o);
      end else begin
        m = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end
      send_matrix(m);
    end
  endtask

  // Receiver stalls long enough for full to rise while items keep coming
  task automatic test_backpressure();
    int k;
    pop_hold = 200;
    for (k = 0; k < 80; k++)
      send_matrix(item_t'({$urandom, $urandom, $urandom, $urandom, $urandom}), 1'b1);
    // sender pause until everything has arrived
    wait_drained();
    pop_steady = 1'b1;
    for (k = 0; k < 30; k++)
      send_matrix(item_t'({$urandom, $urandom, $urandom, $urandom, $urandom}), 1'b1);
    wait_drained();
    pop_steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(530);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && quat_expected.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
